/* rtl/smf_track_event_parser_unit_macros.svh */
// Assertion macros for the track event parser RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef SMF_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define SMF_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`ifndef SYNTH
// Concurrent same-cycle form, checked at every rising clock edge outside reset.
`define SMF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("smf assertion failed");
// Next-cycle form: when ante holds, cons must hold in the next cycle.
`define SMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("smf assertion failed");
`else
`define SMF_ASSERT(lbl, clk, rstn, prop)
`define SMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/smf_pkg.sv */
// Shared types, constants and helpers for the track event parser.
// No dependencies.
package smf_pkg;

    localparam int unsigned QueueDepthDefault = 4;

    localparam logic [14:0] TpqReset      = 15'd96;
    localparam logic [23:0] TempoReset    = 24'd500000;
    localparam logic [23:0] UptReset      = 24'(500000 / 96);
    localparam logic [7:0]  LastSentReset = 8'hF1;

    localparam logic [7:0] MetaTempo   = 8'd81;
    localparam logic [7:0] StSysex     = 8'hF0;
    localparam logic [7:0] StSysexEsc  = 8'hF7;
    localparam logic [7:0] StMeta      = 8'hFF;
    localparam logic [7:0] StSystem    = 8'hF0;
    localparam logic [7:0] OneDataLow  = 8'd192;
    localparam logic [7:0] OneDataHigh = 8'd223;

    // Configuration register indexes.
    localparam logic CfgTicksPerQuarter = 1'b0;
    localparam logic CfgInitialTempo    = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHANNEL,
        KIND_TEMPO,
        KIND_END,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_CHAN,
        OP_TEMPO,
        OP_ERR
    } t_op;

    // One command from the parser to the timing back end.
    typedef struct packed {
        logic        song;
        logic        clr;
        logic        eot;
        t_op         op;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  cnt;
        logic [27:0] arg;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [1:0]  cnt;
        logic        snd;
        logic [31:0] delta;
    } t_res;

    function automatic logic two_data(input logic [7:0] st);
        return (st < OneDataLow) || (st > OneDataHigh);
    endfunction

endpackage

/* rtl/smf_if.sv */
// Handshake channels of the track event parser: input bytes, results, configuration.
// No dependencies.
interface smf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] track_byte;
    logic       track_start;
    logic       song_start;
    logic       end_of_track;
    modport source (output valid, track_byte, track_start, song_start, end_of_track,
                    input ready);
    modport sink (input valid, track_byte, track_start, song_start, end_of_track,
                  output ready);
endinterface

interface smf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [1:0]  data_count;
    logic        send_status;
    logic [31:0] delta_us;
    modport source (output valid, result_kind, status_byte, first_data, second_data,
                    data_count, send_status, delta_us, input ready);
    modport sink (input valid, result_kind, status_byte, first_data, second_data,
                  data_count, send_status, delta_us, output ready);
endinterface

interface smf_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/smf_front.sv */
// Byte parser: walks the track syntax and issues commands to the back end.
// Depends on smf_pkg and smf_in_if.
module smf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    smf_in_if.sink        i_in,
    output logic          o_push,
    output smf_pkg::t_cmd o_cmd,
    input  logic          i_full
);
    import smf_pkg::*;

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_META_TYPE,
        PH_META_LEN,
        PH_SYSEX_LEN,
        PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [27:0] r_vlq, n_vlq;
    logic [2:0]  r_vbytes, n_vbytes;
    logic [7:0]  r_rs, n_rs;
    logic [6:0]  r_held, n_held;
    logic [7:0]  r_meta, n_meta;
    logic [27:0] r_skip, n_skip;

    logic [7:0]  w_b;
    logic [27:0] w_cat;
    logic [2:0]  w_cnt;
    logic        w_done;
    logic        w_end_skip;
    logic        w_chan;
    logic [6:0]  w_c1;
    logic [6:0]  w_c2;
    logic        w_need;
    t_cmd        w_cmd;

    // Tempo bytes that did not arrive count as zero in their place.
    function automatic logic [23:0] tempo_of(input logic [27:0] v, input logic [2:0] nb);
        logic [23:0] t;
        if (nb >= 3'd3) begin
            t = v[23:0];
        end else if (nb == 3'd2) begin
            t = {v[15:0], 8'd0};
        end else if (nb == 3'd1) begin
            t = {v[7:0], 16'd0};
        end else begin
            t = '0;
        end
        return t;
    endfunction

    assign w_b = i_in.track_byte;

    always_comb begin
        n_phase  = r_phase;
        n_vlq    = r_vlq;
        n_vbytes = r_vbytes;
        n_rs     = r_rs;
        n_held   = r_held;
        n_meta   = r_meta;
        n_skip   = r_skip;
        if (i_in.track_start) begin
            n_phase  = PH_DELTA;
            n_vlq    = '0;
            n_vbytes = '0;
            n_rs     = '0;
            n_held   = '0;
            n_meta   = '0;
            n_skip   = '0;
        end
        w_cmd        = '0;
        w_cmd.song   = i_in.song_start;
        w_cmd.clr    = i_in.track_start;
        w_cmd.eot    = i_in.end_of_track;
        w_cmd.op     = OP_NONE;
        w_cat        = {n_vlq[20:0], w_b[6:0]};
        w_cnt        = n_vbytes + 3'd1;
        w_done       = !w_b[7] || (w_cnt >= 3'd4);
        w_end_skip   = 1'b0;
        w_chan       = 1'b0;
        w_c1         = '0;
        w_c2         = '0;

        unique case (n_phase)
            PH_STATUS: begin
                if (w_b[7]) begin
                    if (w_b < StSystem) begin
                        n_rs    = w_b;
                        n_phase = PH_DATA1;
                    end else begin
                        n_rs     = '0;
                        n_vlq    = '0;
                        n_vbytes = '0;
                        if (w_b == StMeta) begin
                            n_phase = PH_META_TYPE;
                        end else if (w_b == StSysex || w_b == StSysexEsc) begin
                            n_meta  = 8'hFF;
                            n_phase = PH_SYSEX_LEN;
                        end else begin
                            n_meta  = 8'hFF;
                            n_phase = PH_DELTA;
                        end
                    end
                end else if (n_rs == '0) begin
                    w_cmd.op = OP_ERR;
                    n_phase  = PH_DELTA;
                end else if (!two_data(n_rs)) begin
                    w_chan = 1'b1;
                    w_c1   = w_b[6:0];
                end else begin
                    n_held  = w_b[6:0];
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA1: begin
                if (!two_data(n_rs)) begin
                    w_chan = 1'b1;
                    w_c1   = w_b[6:0];
                end else begin
                    n_held  = w_b[6:0];
                    n_phase = PH_DATA2;
                end
            end
            PH_DATA2: begin
                w_chan = 1'b1;
                w_c1   = n_held;
                w_c2   = w_b[6:0];
            end
            PH_META_TYPE: begin
                n_meta   = w_b;
                n_vlq    = '0;
                n_vbytes = '0;
                n_phase  = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN: begin
                n_vlq    = w_cat;
                n_vbytes = w_cnt;
                if (w_done) begin
                    n_skip   = w_cat;
                    n_vlq    = '0;
                    n_vbytes = '0;
                    if (w_cat == '0) begin
                        w_end_skip = 1'b1;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (n_meta == MetaTempo && n_vbytes < 3'd3) begin
                    n_vlq    = {4'd0, n_vlq[15:0], w_b};
                    n_vbytes = w_cnt;
                end
                n_skip = n_skip - 28'd1;
                if (n_skip == '0) begin
                    w_end_skip = 1'b1;
                end
            end
            PH_DELTA: begin
                n_vlq    = w_cat;
                n_vbytes = w_cnt;
                if (w_done) begin
                    w_cmd.op  = OP_ADD;
                    w_cmd.arg = w_cat;
                    n_vlq     = '0;
                    n_vbytes  = '0;
                    n_phase   = PH_STATUS;
                end else begin
                    n_phase = PH_DELTA;
                end
            end
        endcase

        if (w_chan) begin
            w_cmd.op     = OP_CHAN;
            w_cmd.status = n_rs;
            w_cmd.d1     = w_c1;
            w_cmd.d2     = two_data(n_rs) ? w_c2 : 7'd0;
            w_cmd.cnt    = two_data(n_rs) ? 2'd2 : 2'd1;
            n_phase      = PH_DELTA;
        end

        if (w_end_skip) begin
            n_phase = PH_DELTA;
            if (n_meta == MetaTempo) begin
                w_cmd.op  = OP_TEMPO;
                w_cmd.arg = {4'd0, tempo_of(n_vlq, n_vbytes)};
                n_meta    = '0;
            end
        end

        if (i_in.end_of_track) begin
            n_phase  = PH_DELTA;
            n_vlq    = '0;
            n_vbytes = '0;
            n_rs     = '0;
            n_held   = '0;
            n_meta   = '0;
            n_skip   = '0;
        end
    end

    assign w_need     = (w_cmd.op != OP_NONE) || w_cmd.song || w_cmd.clr || w_cmd.eot;
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full && w_need;
    assign o_cmd      = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DELTA;
            r_vlq    <= '0;
            r_vbytes <= '0;
            r_rs     <= '0;
            r_held   <= '0;
            r_meta   <= '0;
            r_skip   <= '0;
        end else if (i_in.valid && !i_full) begin
            r_phase  <= n_phase;
            r_vlq    <= n_vlq;
            r_vbytes <= n_vbytes;
            r_rs     <= n_rs;
            r_held   <= n_held;
            r_meta   <= n_meta;
            r_skip   <= n_skip;
        end
    end

endmodule

/* rtl/smf_queue.sv */
// Small command queue between the parser and the back end.
// Depends on smf_pkg and the assertion macro header.
`include "smf_track_event_parser_unit_macros.svh"
module smf_queue #(
    parameter int unsigned Depth = smf_pkg::QueueDepthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  smf_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output smf_pkg::t_cmd o_data
);
    import smf_pkg::*;

    localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CountW = $clog2(Depth + 1);
    localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
    localparam logic [CountW-1:0] Full     = CountW'(Depth);

    t_cmd              r_mem [Depth];
    logic [AddrW-1:0]  r_wr;
    logic [AddrW-1:0]  r_rd;
    logic [CountW-1:0] r_count;

    assign o_full  = (r_count == Full);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LastAddr) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LastAddr) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SMF_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `SMF_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid)
    `SMF_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, (i_push && !i_pop), (r_count == $past(r_count) + 1'b1))

endmodule

/* rtl/smf_div.sv */
// Restoring divider, one quotient bit per cycle, for the tick factor.
// No dependencies.
module smf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [14:0] i_divisor,
    output logic        o_done,
    output logic [23:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [14:0] r_rem;
    logic [23:0] r_quo;
    logic [14:0] r_div;

    logic [15:0] w_shift;
    logic [15:0] w_diff;
    logic        w_ge;

    assign w_shift = {r_rem, r_quo[23]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd23;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[14:0] : w_shift[14:0];
                r_quo <= {r_quo[22:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/smf_back.sv */
// Timing back end: scales deltas, runs the tempo division and forms results.
// Depends on smf_pkg, smf_out_if, smf_div and the assertion macro header.
`include "smf_track_event_parser_unit_macros.svh"
module smf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  smf_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic [14:0]   i_tpq,
    input  logic [23:0]   i_init_tempo,
    smf_out_if.source     o_res
);
    import smf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_OP,
        S_ACC,
        S_EOT,
        S_PUT
    } t_state;

    t_state      r_state;
    t_state      r_ret;
    t_cmd        r_cmd;
    logic        r_had;
    logic        r_song_div;
    logic [23:0] r_upt;
    logic [31:0] r_pending;
    logic [7:0]  r_last;
    logic [51:0] r_prod;
    t_res        r_res;
    t_res        r_out;
    logic        r_out_valid;

    logic        w_div_start;
    logic [23:0] w_div_dvd;
    logic [14:0] w_div_dvs;
    logic        w_div_done;
    logic [23:0] w_quo;
    logic [52:0] w_sum;
    logic        w_load;

    function automatic t_res mk_res(input t_kind k, input logic [7:0] st,
                                    input logic [6:0] d1, input logic [6:0] d2,
                                    input logic [1:0] cnt, input logic snd,
                                    input logic [31:0] dl);
        t_res r;
        r.kind   = k;
        r.status = st;
        r.d1     = d1;
        r.d2     = d2;
        r.cnt    = cnt;
        r.snd    = snd;
        r.delta  = dl;
        return r;
    endfunction

    assign o_pop       = (r_state == S_IDLE) && i_valid;
    assign w_div_start = ((r_state == S_IDLE) && i_valid && i_cmd.song)
                       || ((r_state == S_OP) && (r_cmd.op == OP_TEMPO));
    assign w_div_dvd   = (r_state == S_IDLE) ? i_init_tempo : r_cmd.arg[23:0];
    assign w_div_dvs   = (i_tpq == '0) ? 15'd1 : i_tpq;
    assign w_sum       = {21'd0, r_pending} + {1'b0, r_prod};
    assign w_load      = (r_state == S_PUT) && (!r_out_valid || o_res.ready);

    smf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_res.valid       = r_out_valid;
    assign o_res.result_kind = r_out.kind;
    assign o_res.status_byte = r_out.status;
    assign o_res.first_data  = r_out.d1;
    assign o_res.second_data = r_out.d2;
    assign o_res.data_count  = r_out.cnt;
    assign o_res.send_status = r_out.snd;
    assign o_res.delta_us    = r_out.delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_had       <= 1'b0;
            r_song_div  <= 1'b0;
            r_upt       <= UptReset;
            r_pending   <= '0;
            r_last      <= LastSentReset;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd      <= i_cmd;
                        r_had      <= 1'b0;
                        r_song_div <= i_cmd.song;
                        if (i_cmd.clr) begin
                            r_pending <= '0;
                        end
                        r_state <= i_cmd.song ? S_DIV : S_OP;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_upt <= w_quo;
                        if (r_song_div) begin
                            r_state <= S_OP;
                        end else begin
                            r_res     <= mk_res(KIND_TEMPO, '0, '0, '0, '0, 1'b0, r_pending);
                            r_pending <= '0;
                            r_had     <= 1'b1;
                            r_ret     <= S_EOT;
                            r_state   <= S_PUT;
                        end
                    end
                end
                S_OP: begin
                    unique case (r_cmd.op)
                        OP_ADD: begin
                            r_prod  <= r_upt * r_cmd.arg;
                            r_state <= S_ACC;
                        end
                        OP_TEMPO: begin
                            r_song_div <= 1'b0;
                            r_state    <= S_DIV;
                        end
                        OP_CHAN: begin
                            r_res     <= mk_res(KIND_CHANNEL, r_cmd.status, r_cmd.d1,
                                                r_cmd.d2, r_cmd.cnt,
                                                r_cmd.status != r_last, r_pending);
                            r_last    <= r_cmd.status;
                            r_pending <= '0;
                            r_had     <= 1'b1;
                            r_ret     <= S_EOT;
                            r_state   <= S_PUT;
                        end
                        OP_ERR: begin
                            r_res   <= mk_res(KIND_ERROR, '0, '0, '0, '0, 1'b0, '0);
                            r_had   <= 1'b1;
                            r_ret   <= S_EOT;
                            r_state <= S_PUT;
                        end
                        default: begin
                            r_state <= S_EOT;
                        end
                    endcase
                end
                S_ACC: begin
                    r_pending <= (w_sum[52:32] != '0) ? 32'hFFFF_FFFF : w_sum[31:0];
                    r_state   <= S_EOT;
                end
                S_EOT: begin
                    if (r_cmd.eot) begin
                        r_pending <= '0;
                        if (!r_had) begin
                            r_res   <= mk_res(KIND_END, '0, '0, '0, '0, 1'b0, r_pending);
                            r_had   <= 1'b1;
                            r_ret   <= S_IDLE;
                            r_state <= S_PUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PUT: begin
                    if (w_load) begin
                        r_out   <= r_res;
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SMF_ASSERT(a_div_start_ctx, i_clk, i_rst_n, w_div_start |-> (r_state == S_IDLE || r_state == S_OP))
    `SMF_ASSERT_NEXT(a_eot_clears, i_clk, i_rst_n, (r_state == S_EOT && r_cmd.eot), (r_pending == '0))
    `SMF_ASSERT_NEXT(a_put_loads, i_clk, i_rst_n, (r_state == S_PUT && !r_out_valid), r_out_valid)

endmodule

/* rtl/smf_track_event_parser_unit.sv */
// Top level of the track event parser: configuration registers, parser, queue, back end.
// Depends on smf_pkg, smf_if, smf_front, smf_queue and smf_back.
//
//  Port     Direction  Word carries
//  i_in     in         one track byte with its track, song and end flags
//  i_cfg    in         register index and write data (ticks per quarter, initial tempo)
//  o_res    out        one result: kind, status, data bytes, send flag, delta in us
//
// The parser takes one byte per cycle while the command queue has room; bytes that
// need no timing work produce no command. The back end takes each command through its
// idle, operation and end-of-track states, an accumulate state for a scaled delta, a
// put state for each result word it hands over, and a divide state for each division
// that a song start or a tempo event sets off in the shared one-bit-per-cycle divider.
// Reset is synchronous and active low and clears all parse and timing state.
// A stalled result holds the back end, which then fills the queue and stalls input.
module smf_track_event_parser_unit #(
    parameter int unsigned QueueDepth = smf_pkg::QueueDepthDefault
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smf_in_if.sink     i_in,
    smf_cfg_if.sink    i_cfg,
    smf_out_if.source  o_res
);
    import smf_pkg::*;

    // Configuration registers. A write takes effect at the next division that
    // uses them, that is at the next song start or tempo event.
    logic [14:0] r_tpq;
    logic [23:0] r_init_tempo;

    logic w_push;
    t_cmd w_push_cmd;
    logic w_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpq        <= TpqReset;
            r_init_tempo <= TempoReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CfgTicksPerQuarter: r_tpq        <= i_cfg.data[14:0];
                CfgInitialTempo:    r_init_tempo <= i_cfg.data;
            endcase
        end
    end

    // Front: the syntax walk over the byte stream.
    smf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd),
        .i_full  (w_full)
    );

    // The queue lets the parser run ahead while a division or a stalled result
    // holds the back end.
    smf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd)
    );

    // Back: delta scaling, tempo factor, running status compression, results.
    smf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_cmd        (w_q_cmd),
        .o_pop        (w_pop),
        .i_tpq        (r_tpq),
        .i_init_tempo (r_init_tempo),
        .o_res        (o_res)
    );

endmodule
